// ===== src/mrtu_pkg.sv =====
// mrtu_pkg: shared types, codes and the CRC-16/MODBUS byte step for the
// RTU slave frame engine. No dependencies.
package mrtu_pkg;

    localparam int KEEP_BYTES  = 8;
    localparam int QUEUE_DEPTH = 2;

    // command kinds passed from front to back
    localparam logic [1:0] KIND_SILENT = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_WRITE  = 2'd2;
    localparam logic [1:0] KIND_EXC    = 2'd3;

    // frame status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_CRC     = 2'd2;
    localparam logic [1:0] STAT_EXC     = 2'd3;

    // function and exception codes
    localparam logic [7:0] FC_READ_HOLD  = 8'h03;
    localparam logic [7:0] FC_WRITE_ONE  = 8'h06;
    localparam logic [7:0] FC_EXC_FLAG   = 8'h80;
    localparam logic [7:0] EXC_ILL_FUNC  = 8'h01;
    localparam logic [7:0] EXC_ILL_ADDR  = 8'h02;
    localparam logic [7:0] EXC_ILL_VALUE = 8'h03;
    localparam logic [7:0] BCAST_ADDR    = 8'h00;
    localparam logic [15:0] FC03_MAX     = 16'd125;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    // configuration register index (paddr[2])
    localparam logic REG_SLAVE_ADDR = 1'b0;

    typedef struct packed {
        logic [1:0]      kind;
        logic [1:0]      status;
        logic [7:0]      hdr1;   // response byte 1 for READ / EXC
        logic [7:0]      hdr2;   // response byte 2 for READ / EXC
        logic [7:0][7:0] bytes;  // first eight request bytes
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/mrtu_front.sv =====
// mrtu_front: byte intake, frame capture, running CRC and frame
// classification into commands. Depends on mrtu_pkg.
module mrtu_front #(
    parameter int HOLDING_COUNT   = 16,
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    input  logic                 frame_end,
    input  logic [7:0]           slave_addr,
    input  mrtu_pkg::q_status_t  q_status,
    output logic                 push,
    output mrtu_pkg::cmd_t       push_cmd
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [7:0]       bytes_reg [mrtu_pkg::KEEP_BYTES];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;
    logic             ovf_reg, ovf_next;

    logic             accept;
    logic             at_max;
    logic [7:0][7:0]  b_n;
    logic [15:0]      a_val, v_val;
    logic [16:0]      a_plus_v;
    logic             len_ok;
    mrtu_pkg::cmd_t   cmd;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign at_max   = (count_reg >= CNT_W'(MAX_FRAME_BYTES));

    always_comb
    begin
        for (int k = 0; k < mrtu_pkg::KEEP_BYTES; k++)
        begin
            b_n[k] = (count_reg == CNT_W'(k)) ? rx_byte : bytes_reg[k];
        end
    end

    assign count_next = at_max ? count_reg : count_reg + CNT_W'(1);
    assign ovf_next   = ovf_reg || at_max;
    assign crc_next   = mrtu_pkg::crc16_byte(crc_reg, rx_byte);
    assign a_val      = {b_n[2], b_n[3]};
    assign v_val      = {b_n[4], b_n[5]};
    assign a_plus_v   = {1'b0, a_val} + {1'b0, v_val};
    assign len_ok     = (count_next == CNT_W'(8));

    always_comb
    begin
        cmd        = '0;
        cmd.bytes  = b_n;
        cmd.kind   = mrtu_pkg::KIND_EXC;
        cmd.status = mrtu_pkg::STAT_EXC;
        cmd.hdr1   = b_n[1] | mrtu_pkg::FC_EXC_FLAG;
        cmd.hdr2   = mrtu_pkg::EXC_ILL_FUNC;
        priority if (ovf_next || count_next < CNT_W'(4))
        begin
            cmd.kind   = mrtu_pkg::KIND_SILENT;
            cmd.status = mrtu_pkg::STAT_IGNORED;
        end
        else if (b_n[0] == mrtu_pkg::BCAST_ADDR || b_n[0] != slave_addr)
        begin
            cmd.kind   = mrtu_pkg::KIND_SILENT;
            cmd.status = mrtu_pkg::STAT_IGNORED;
        end
        else if (crc_next != 16'h0000)
        begin
            cmd.kind   = mrtu_pkg::KIND_SILENT;
            cmd.status = mrtu_pkg::STAT_CRC;
        end
        else if (b_n[1] == mrtu_pkg::FC_READ_HOLD)
        begin
            priority if (!len_ok || v_val == 16'd0 || v_val > mrtu_pkg::FC03_MAX)
            begin
                cmd.hdr2 = mrtu_pkg::EXC_ILL_VALUE;
            end
            else if (a_plus_v > 17'(HOLDING_COUNT))
            begin
                cmd.hdr2 = mrtu_pkg::EXC_ILL_ADDR;
            end
            else
            begin
                cmd.kind   = mrtu_pkg::KIND_READ;
                cmd.status = mrtu_pkg::STAT_OK;
                cmd.hdr1   = mrtu_pkg::FC_READ_HOLD;
                cmd.hdr2   = {b_n[5][6:0], 1'b0};
            end
        end
        else if (b_n[1] == mrtu_pkg::FC_WRITE_ONE)
        begin
            priority if (!len_ok)
            begin
                cmd.hdr2 = mrtu_pkg::EXC_ILL_VALUE;
            end
            else if (a_val >= 16'(HOLDING_COUNT))
            begin
                cmd.hdr2 = mrtu_pkg::EXC_ILL_ADDR;
            end
            else
            begin
                cmd.kind   = mrtu_pkg::KIND_WRITE;
                cmd.status = mrtu_pkg::STAT_OK;
            end
        end
        else
        begin
            cmd.hdr2 = mrtu_pkg::EXC_ILL_FUNC;
        end
    end

    assign push     = accept && frame_end;
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= mrtu_pkg::CRC_INIT;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                count_reg <= '0;
                crc_reg   <= mrtu_pkg::CRC_INIT;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                crc_reg   <= crc_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && count_reg < CNT_W'(mrtu_pkg::KEEP_BYTES))
        begin
            bytes_reg[count_reg[2:0]] <= rx_byte;
        end
    end

endmodule

// ===== src/mrtu_queue.sv =====
// mrtu_queue: two-entry command queue between front and back.
// Depends on mrtu_pkg.
module mrtu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mrtu_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output mrtu_pkg::cmd_t      head,
    output mrtu_pkg::q_status_t status
);

    mrtu_pkg::cmd_t mem_reg [mrtu_pkg::QUEUE_DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_push, do_pop;

    assign status.full  = (count_reg == 2'(mrtu_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg ^ do_push;
    assign rd_ptr_next = rd_ptr_reg ^ do_pop;
    assign count_next  = count_reg + 2'(do_push) - 2'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/mrtu_back.sv =====
// mrtu_back: executes commands, owns the holding-register store, builds
// response beats with their CRC into the output register. Depends on mrtu_pkg.
module mrtu_back #(
    parameter int HOLDING_COUNT = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mrtu_pkg::cmd_t      head,
    input  mrtu_pkg::q_status_t q_status,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          tx_byte,
    output logic                tx_valid,
    output logic                tx_last,
    output logic [1:0]          frame_status
);

    localparam int HIDX_W = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
    localparam int LEN_W  = $clog2(2 * HOLDING_COUNT + 6);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    logic [15:0]      hregs_reg [HOLDING_COUNT];
    logic             state_reg, state_next;
    mrtu_pkg::cmd_t   cmd_reg;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] lastidx_reg, lastidx_next;
    logic [15:0]      crc_reg, crc_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       tx_byte_reg;
    logic             tx_valid_reg, tx_last_reg;
    logic [1:0]       status_reg;

    logic             can_emit, emit;
    logic [7:0]       beat_byte;
    logic             beat_last;
    logic [LEN_W-1:0] ofs;
    logic [HIDX_W-1:0] rd_idx, wr_idx;
    logic [15:0]      rd_data;

    assign pop      = (state_reg == ST_IDLE) && !q_status.empty;
    assign can_emit = !out_valid_reg || !out_stall;
    assign emit     = (state_reg == ST_SEND) && can_emit;
    assign beat_last = (idx_reg == lastidx_reg);

    assign ofs     = (idx_reg - LEN_W'(3)) >> 1;
    assign rd_idx  = cmd_reg.bytes[3][HIDX_W-1:0] + HIDX_W'(ofs);
    assign rd_data = (32'(rd_idx) < 32'(HOLDING_COUNT)) ? hregs_reg[rd_idx] : 16'h0000;
    assign wr_idx  = head.bytes[3][HIDX_W-1:0];

    always_comb
    begin
        beat_byte = 8'h00;
        unique case (cmd_reg.kind)
            mrtu_pkg::KIND_SILENT:
            begin
                beat_byte = 8'h00;
            end
            mrtu_pkg::KIND_WRITE:
            begin
                beat_byte = cmd_reg.bytes[idx_reg[2:0]];
            end
            mrtu_pkg::KIND_READ, mrtu_pkg::KIND_EXC:
            begin
                priority if (idx_reg == LEN_W'(0))
                    beat_byte = cmd_reg.bytes[0];
                else if (idx_reg == LEN_W'(1))
                    beat_byte = cmd_reg.hdr1;
                else if (idx_reg == LEN_W'(2))
                    beat_byte = cmd_reg.hdr2;
                else if (beat_last)
                    beat_byte = crc_reg[15:8];
                else if (idx_reg == lastidx_reg - LEN_W'(1))
                    beat_byte = crc_reg[7:0];
                else
                    beat_byte = idx_reg[0] ? rd_data[15:8] : rd_data[7:0];
            end
            default:
            begin
                beat_byte = 8'h00;
            end
        endcase
    end

    always_comb
    begin
        unique case (head.kind)
            mrtu_pkg::KIND_SILENT: lastidx_next = LEN_W'(0);
            mrtu_pkg::KIND_EXC:    lastidx_next = LEN_W'(4);
            mrtu_pkg::KIND_WRITE:  lastidx_next = LEN_W'(7);
            default:               lastidx_next = LEN_W'(4) + LEN_W'({head.bytes[5], 1'b0});
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        if (pop)
        begin
            state_next = ST_SEND;
            idx_next   = '0;
            crc_next   = mrtu_pkg::CRC_INIT;
        end
        else if (emit)
        begin
            idx_next = idx_reg + LEN_W'(1);
            // CRC covers the message bytes only, not its own two bytes
            if (idx_reg < lastidx_reg - LEN_W'(1))
            begin
                crc_next = mrtu_pkg::crc16_byte(crc_reg, beat_byte);
            end
            if (beat_last)
            begin
                state_next = ST_IDLE;
            end
        end
    end

    assign out_valid_next = emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < HOLDING_COUNT; k++)
            begin
                hregs_reg[k] <= 16'h0000;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (pop && head.kind == mrtu_pkg::KIND_WRITE)
            begin
                hregs_reg[wr_idx] <= {head.bytes[4], head.bytes[5]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        crc_reg <= crc_next;
        if (pop)
        begin
            cmd_reg     <= head;
            lastidx_reg <= lastidx_next;
        end
        if (emit)
        begin
            tx_byte_reg  <= beat_byte;
            tx_valid_reg <= (cmd_reg.kind != mrtu_pkg::KIND_SILENT);
            tx_last_reg  <= beat_last;
            status_reg   <= cmd_reg.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tx_byte      = tx_byte_reg;
    assign tx_valid     = tx_valid_reg;
    assign tx_last      = tx_last_reg;
    assign frame_status = status_reg;

endmodule

// ===== src/modbus_rtu_slave_frame_engine.sv =====
// Modbus RTU slave frame engine, FC03/FC06: top level with APB config port.
// Depends on mrtu_pkg, mrtu_front, mrtu_queue, mrtu_back.
// Throughput: one received byte per cycle; in_stall is high only while the
// two-entry command queue is full. Response: with the back end idle, it pops
// the queued command and then sends one beat per cycle while out_stall is low,
// 1 to 5 + 2*HOLDING_COUNT beats. Reset: registers cleared, address 1.
module modbus_rtu_slave_frame_engine #(
    parameter int HOLDING_COUNT   = 16,
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tx_byte,
    output logic        tx_valid,
    output logic        tx_last,
    output logic [1:0]  frame_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]          slave_reg, slave_next;
    logic                cfg_wr;
    logic                push, pop;
    mrtu_pkg::cmd_t      push_cmd, head;
    mrtu_pkg::q_status_t q_status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == mrtu_pkg::REG_SLAVE_ADDR);
    assign slave_next = cfg_wr ? pwdata[7:0] : slave_reg;
    assign prdata = (paddr[2] == mrtu_pkg::REG_SLAVE_ADDR) ? {24'h000000, slave_reg}
                                                           : 32'h00000000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_reg <= 8'h01;
        end
        else
        begin
            slave_reg <= slave_next;
        end
    end

    mrtu_front #(
        .HOLDING_COUNT   (HOLDING_COUNT),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .frame_end  (frame_end),
        .slave_addr (slave_reg),
        .q_status   (q_status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    mrtu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    mrtu_back #(
        .HOLDING_COUNT (HOLDING_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tx_byte      (tx_byte),
        .tx_valid     (tx_valid),
        .tx_last      (tx_last),
        .frame_status (frame_status)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("command pushed into full queue");

    a_silent_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !tx_valid) |-> tx_last)
        else $error("silent beat not marked last");

    a_quiet_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (frame_status == mrtu_pkg::STAT_IGNORED
                       || frame_status == mrtu_pkg::STAT_CRC)) |-> !tx_valid)
        else $error("byte sent for ignored or bad-CRC frame");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for the Modbus RTU slave frame engine (FC03/FC06).
// Drives frames byte by byte, predicts each response beat from its own frame
// model or the directed table, and checks the beats in order. Depends on mrtu_pkg and the engine RTL.
module tb;

    localparam int HOLD_N      = 16;
    localparam int MAX_FRAME   = 256;
    localparam int REQ_LEN     = 8;
    localparam int MIN_LEN     = 4;
    localparam int HOLD_CYCLES = 250;
    localparam int RAND_BYTES  = 27;
    localparam int DIR_N       = 6;
    localparam logic [2:0] STATION_REG_ADDR = {mrtu_pkg::REG_SLAVE_ADDR, 2'b00};

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic [1:0] status;
    } tx_beat_t;

    typedef struct packed {
        logic [7:0]  adr;
        logic [7:0]  fc;
        logic [15:0] ra;
        logic [15:0] rv;
        logic [9:0]  len;
        logic        bad_crc;
        logic        typed;
        logic [1:0]  tstat;
    } frame_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        tx_last;
    logic [1:0]  frame_status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // frame model state
    logic [7:0]  station_id;
    logic [7:0]  head_bytes [mrtu_pkg::KEEP_BYTES];
    int unsigned frame_len;
    logic [15:0] crc_acc;
    bit          frame_overrun;
    logic [15:0] hold_regs [HOLD_N];

    tx_beat_t    reply_beats [$];
    tx_beat_t    expected_tx [$];
    logic [7:0]  frame_q [$];

    int          mismatches;
    int          burst_left;
    int          beats_in;
    int          beats_out;
    int          frames_sent;
    int          input_stalls;
    int          outcome_cnt [4];
    bit          hold_req;
    bit          hold_done;

    // short, broadcast, bad CRC, unknown function, write top register, read all
    frame_row_t dir_frames [DIR_N] = '{
        '{8'hFF, 8'h00, 16'h0000, 16'h0000, 10'd1, 1'b0, 1'b1, mrtu_pkg::STAT_IGNORED},
        '{mrtu_pkg::BCAST_ADDR, mrtu_pkg::FC_READ_HOLD, 16'h0000, 16'h0001, 10'd4,
          1'b0, 1'b1, mrtu_pkg::STAT_IGNORED},
        '{8'h01, mrtu_pkg::FC_READ_HOLD, 16'h0000, 16'h0001, 10'd4, 1'b1, 1'b1,
          mrtu_pkg::STAT_CRC},
        '{8'h01, 8'h00, 16'h0000, 16'h0000, 10'd4, 1'b0, 1'b0, mrtu_pkg::STAT_OK},
        '{8'h01, mrtu_pkg::FC_WRITE_ONE, 16'h000F, 16'hFFFF, 10'd8, 1'b0, 1'b0,
          mrtu_pkg::STAT_OK},
        '{8'h01, mrtu_pkg::FC_READ_HOLD, 16'h0000, 16'h0010, 10'd8, 1'b0, 1'b0,
          mrtu_pkg::STAT_OK}
    };

    modbus_rtu_slave_frame_engine #(
        .HOLDING_COUNT   (HOLD_N),
        .MAX_FRAME_BYTES (MAX_FRAME)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tx_byte      (tx_byte),
        .tx_valid     (tx_valid),
        .tx_last      (tx_last),
        .frame_status (frame_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("modbus_rtu_slave_frame_engine verification failed");
        $finish;
    end

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH: %s", msg);
    endfunction

    // bit-serial CRC-16/MODBUS, data fed LSB first
    function automatic logic [15:0] crc_modbus_next(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        int          k;
        r = c;
        for (k = 0; k < 8; k++)
        begin
            fb = r[0] ^ d[k];
            r  = r >> 1;
            if (fb)
                r = r ^ mrtu_pkg::CRC_POLY;
        end
        return r;
    endfunction

    function automatic void build_reply();
        logic [7:0] resp [$];
        logic [7:0] fc;
        logic [7:0] code;
        logic [1:0] stat;
        logic [15:0] c;
        bit         is_exc;
        bit         echo;
        int         ra;
        int         rv;
        int         k;
        if (frame_overrun || frame_len < MIN_LEN || head_bytes[0] == mrtu_pkg::BCAST_ADDR ||
            head_bytes[0] != station_id)
        begin
            reply_beats.push_back(tx_beat_t'{8'h00, 1'b0, 1'b1, mrtu_pkg::STAT_IGNORED});
            return;
        end
        if (crc_acc != 16'h0000)
        begin
            reply_beats.push_back(tx_beat_t'{8'h00, 1'b0, 1'b1, mrtu_pkg::STAT_CRC});
            return;
        end
        fc     = head_bytes[1];
        ra     = int'({head_bytes[2], head_bytes[3]});
        rv     = int'({head_bytes[4], head_bytes[5]});
        is_exc = 1'b1;
        echo   = 1'b0;
        code   = mrtu_pkg::EXC_ILL_FUNC;
        stat   = mrtu_pkg::STAT_OK;
        if (fc == mrtu_pkg::FC_READ_HOLD)
        begin
            if (frame_len != REQ_LEN || rv == 0 || rv > mrtu_pkg::FC03_MAX)
                code = mrtu_pkg::EXC_ILL_VALUE;
            else if (ra + rv > HOLD_N)
                code = mrtu_pkg::EXC_ILL_ADDR;
            else
            begin
                is_exc = 1'b0;
                resp = '{station_id, mrtu_pkg::FC_READ_HOLD, 8'(rv * 2)};
                for (k = 0; k < rv; k++)
                begin
                    resp.push_back(hold_regs[ra + k][15:8]);
                    resp.push_back(hold_regs[ra + k][7:0]);
                end
            end
        end
        else if (fc == mrtu_pkg::FC_WRITE_ONE)
        begin
            if (frame_len != REQ_LEN)
                code = mrtu_pkg::EXC_ILL_VALUE;
            else if (ra >= HOLD_N)
                code = mrtu_pkg::EXC_ILL_ADDR;
            else
            begin
                is_exc = 1'b0;
                echo   = 1'b1;
                hold_regs[ra] = rv[15:0];
                for (k = 0; k < REQ_LEN; k++)
                    resp.push_back(head_bytes[k]);
            end
        end
        if (is_exc)
        begin
            stat = mrtu_pkg::STAT_EXC;
            resp = '{station_id, fc | mrtu_pkg::FC_EXC_FLAG, code};
        end
        if (!echo)
        begin
            c = mrtu_pkg::CRC_INIT;
            for (k = 0; k < resp.size(); k++)
                c = crc_modbus_next(c, resp[k]);
            resp.push_back(c[7:0]);
            resp.push_back(c[15:8]);
        end
        for (k = 0; k < resp.size(); k++)
            reply_beats.push_back(tx_beat_t'{resp[k], 1'b1, k == resp.size() - 1, stat});
    endfunction

    function automatic void slave_absorb_byte(input logic [7:0] b, input bit eof);
        reply_beats.delete();
        if (frame_len >= MAX_FRAME)
            frame_overrun = 1'b1;
        else
        begin
            if (frame_len < mrtu_pkg::KEEP_BYTES)
                head_bytes[frame_len] = b;
            frame_len++;
        end
        crc_acc = crc_modbus_next(crc_acc, b);
        if (eof)
        begin
            build_reply();
            frame_len     = 0;
            crc_acc       = mrtu_pkg::CRC_INIT;
            frame_overrun = 1'b0;
        end
    endfunction

    function automatic void build_frame(input logic [7:0] adr, input logic [7:0] fc,
                                        input logic [15:0] ra, input logic [15:0] rv,
                                        input int n, input bit bad);
        logic [7:0]  hdr [6];
        logic [15:0] c;
        int          body;
        int          k;
        hdr = '{adr, fc, ra[15:8], ra[7:0], rv[15:8], rv[7:0]};
        frame_q.delete();
        body = (n < 3) ? n : n - 2;
        for (k = 0; k < body; k++)
            frame_q.push_back((k < 6) ? hdr[k] : 8'($urandom));
        if (n >= 3)
        begin
            c = mrtu_pkg::CRC_INIT;
            for (k = 0; k < body; k++)
                c = crc_modbus_next(c, frame_q[k]);
            frame_q.push_back(c[7:0]);
            frame_q.push_back(c[15:8]);
            if (bad)
                frame_q[n - 1] = frame_q[n - 1] ^ (8'h01 << $urandom_range(0, 7));
        end
    endfunction

    function automatic void pick_random_frame();
        int          sel;
        int          n;
        logic [7:0]  adr;
        logic [7:0]  fc;
        logic [15:0] ra;
        logic [15:0] rv;
        bit          bad;
        sel = $urandom_range(0, 99);
        adr = station_id;
        fc  = mrtu_pkg::FC_READ_HOLD;
        n   = REQ_LEN;
        bad = 1'b0;
        ra  = 16'($urandom_range(0, HOLD_N - 1));
        rv  = 16'($urandom_range(1, HOLD_N - ra));
        if (rv > 4 && $urandom_range(0, 3) != 0)
            rv = 16'($urandom_range(1, 4));
        if (sel < 30)
            fc = mrtu_pkg::FC_READ_HOLD;
        else if (sel < 50)
        begin
            fc = mrtu_pkg::FC_WRITE_ONE;
            rv = 16'($urandom);
        end
        else if (sel < 55)
            rv = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(126, 65535));
        else if (sel < 60)
        begin
            rv = 16'($urandom_range(1, 125));
            if (rv <= HOLD_N && $urandom_range(0, 1) == 0)
                ra = 16'(HOLD_N + 1 - rv);
            else
                ra = 16'($urandom_range((rv > HOLD_N) ? 0 : HOLD_N + 1 - rv,
                                        65535));
        end
        else if (sel < 65)
        begin
            fc = mrtu_pkg::FC_WRITE_ONE;
            ra = 16'($urandom_range(HOLD_N, 65535));
            rv = 16'($urandom);
        end
        else if (sel < 70)
        begin
            fc = ($urandom_range(0, 1) == 0) ? mrtu_pkg::FC_READ_HOLD : mrtu_pkg::FC_WRITE_ONE;
            n  = ($urandom_range(0, 1) == 0) ? $urandom_range(4, 7) : $urandom_range(9, 12);
        end
        else if (sel < 77)
        begin
            fc = 8'($urandom);
            while (fc == mrtu_pkg::FC_READ_HOLD || fc == mrtu_pkg::FC_WRITE_ONE)
                fc = 8'($urandom);
            n  = $urandom_range(MIN_LEN, REQ_LEN);
            ra = 16'($urandom);
            rv = 16'($urandom);
        end
        else if (sel < 85)
        begin
            fc  = ($urandom_range(0, 1) == 0) ? mrtu_pkg::FC_READ_HOLD : mrtu_pkg::FC_WRITE_ONE;
            bad = 1'b1;
        end
        else if (sel < 92)
            adr = ($urandom_range(0, 2) == 0) ? mrtu_pkg::BCAST_ADDR
                                               : (8'($urandom) ^ station_id) | 8'h01;
        else if (sel < 97)
            n = $urandom_range(1, 3);
        else
        begin
            adr = ($urandom_range(0, 1) == 0) ? station_id : 8'($urandom);
            fc  = 8'($urandom);
            ra  = 16'($urandom);
            rv  = 16'($urandom);
            n   = $urandom_range(1, 10);
            bad = 1'($urandom_range(0, 1));
        end
        if (adr == station_id && sel >= 85 && sel < 92)
            adr = adr ^ 8'h02;
        build_frame(adr, fc, ra, rv, n, bad);
    endfunction

    task automatic send_beat(input logic [7:0] b, input bit eof, input bit typed,
                             input logic [1:0] tstat);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        frame_end <= eof;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        beats_in++;
        slave_absorb_byte(b, eof);
        if (eof)
        begin
            frames_sent++;
            outcome_cnt[reply_beats[0].status]++;
            if (typed)
                expected_tx.push_back(tx_beat_t'{8'h00, 1'b0, 1'b1, tstat});
            else
                foreach (reply_beats[k])
                    expected_tx.push_back(reply_beats[k]);
        end
    endtask

    task automatic send_frame(input bit typed, input logic [1:0] tstat);
        int k;
        for (k = 0; k < frame_q.size(); k++)
            send_beat(frame_q[k], k == frame_q.size() - 1, typed, tstat);
    endtask

    task automatic drain_replies();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_tx.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_station(input logic [7:0] id);
        logic [31:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= STATION_REG_ADDR;
        pwdata  <= {24'h000000, id};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        station_id = id;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[7:0] !== id)
            note_mismatch($sformatf("station readback exp %02h got %02h", id, rd[7:0]));
    endtask

    always @(posedge clk)
    begin
        tx_beat_t want;
        if (rst_n && in_valid && in_stall)
            input_stalls++;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_out++;
            if (expected_tx.size() == 0)
                note_mismatch($sformatf("unexpected beat byte=%02h valid=%b last=%b status=%0d",
                                        tx_byte, tx_valid, tx_last, frame_status));
            else
            begin
                want = expected_tx.pop_front();
                if (tx_byte !== want.data || tx_valid !== want.valid ||
                    tx_last !== want.last || frame_status !== want.status)
                    note_mismatch($sformatf(
                        "beat exp byte=%02h valid=%b last=%b status=%0d, got %02h %b %b %0d",
                        want.data, want.valid, want.last, want.status,
                        tx_byte, tx_valid, tx_last, frame_status));
            end
        end
    end

    // receiver: quiet, light and heavy stall stretches, plus one long hold-off
    initial
    begin : receiver
        int mode;
        int seg;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(10, 60);
            repeat (seg)
            begin
                @(negedge clk);
                if (hold_req && !hold_done)
                begin
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 2) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int          i;
        int          phase;
        int          rbytes;
        frame_row_t  row;
        logic [7:0]  ids [3];
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        frame_end     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        rst_n         = 1'b0;
        mismatches    = 0;
        burst_left    = 0;
        beats_in      = 0;
        beats_out     = 0;
        frames_sent   = 0;
        input_stalls  = 0;
        outcome_cnt   = '{0, 0, 0, 0};
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        station_id    = 8'd1;
        frame_len     = 0;
        crc_acc       = mrtu_pkg::CRC_INIT;
        frame_overrun = 1'b0;
        foreach (head_bytes[k])
            head_bytes[k] = 8'h00;
        foreach (hold_regs[k])
            hold_regs[k] = 16'h0000;
        ids = '{8'd247, 8'($urandom_range(2, 246)), 8'd1};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_station(8'd1);
        for (i = 0; i < DIR_N; i++)
        begin
            row = dir_frames[i];
            build_frame(row.adr, row.fc, row.ra, row.rv, row.len, row.bad_crc);
            send_frame(row.typed, row.tstat);
        end

        rbytes = 0;
        for (phase = 0; phase < 3; phase++)
        begin
            drain_replies();
            set_station(ids[phase]);
            if (phase == 0)
                hold_req = 1'b1;
            while (rbytes < (phase + 1) * RAND_BYTES)
            begin
                pick_random_frame();
                rbytes += frame_q.size();
                send_frame(1'b0, mrtu_pkg::STAT_OK);
            end
        end

        drain_replies();
        repeat (20) @(posedge clk);
        $display("Covered %0d frames, %0d bytes in, %0d beats out, input held %0d cycles",
                 frames_sent, beats_in, beats_out, input_stalls);
        $display("Outcomes: ok %0d, ignored %0d, crc error %0d, exception %0d",
                 outcome_cnt[mrtu_pkg::STAT_OK], outcome_cnt[mrtu_pkg::STAT_IGNORED],
                 outcome_cnt[mrtu_pkg::STAT_CRC], outcome_cnt[mrtu_pkg::STAT_EXC]);
        if (mismatches == 0 && expected_tx.size() == 0)
            $display("modbus_rtu_slave_frame_engine verification clean");
        else
            $display("modbus_rtu_slave_frame_engine verification failed");
        $finish;
    end

endmodule
